/* rtl/ps2md_pkg.sv */
// Shared types, constants and elaboration helpers for the PS/2 mouse packet decoder.
// No dependencies; used by ps2md_cfg, ps2md_core and ps2_mouse_packet_decoder_unit.
package ps2md_pkg;

	localparam int COORD_BITS_DEFAULT = 12;
	localparam int CFG_DATA_BITS      = 13;
	localparam int CFG_INDEX_BITS     = 2;
	localparam int SCREEN_WIDTH_RESET  = 1024;
	localparam int SCREEN_HEIGHT_RESET = 768;

	// register indexes on the config channel
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

	// bit positions in the packet head byte
	localparam int LEFT_BIT   = 0;
	localparam int RIGHT_BIT  = 1;
	localparam int MIDDLE_BIT = 2;
	localparam int SYNC_BIT   = 3;
	localparam int X_SIGN_BIT = 4;
	localparam int Y_SIGN_BIT = 5;

	localparam int MOVE_X_BITS = 9;
	localparam int MOVE_Y_BITS = 10;

	typedef enum logic [2:0] {
		PH_HEAD = 3'b001,
		PH_X    = 3'b010,
		PH_Y    = 3'b100
	} phase_t;

	// button state and edges; left_down is bit 0
	typedef struct packed {
		logic right_pressed;
		logic left_let_go;
		logic left_pressed;
		logic middle_down;
		logic right_down;
		logic left_down;
	} btn_t;

	// one-cycle recentre strobes from the config block
	typedef struct packed {
		logic y;
		logic x;
	} recentre_t;

	// highest legal coordinate for a given screen size (elaboration only)
	function automatic int bound_top(input int size, input int cb);
		if (size < 1)
			return 0;
		if (size > (1 << cb))
			return (1 << cb) - 1;
		return size - 1;
	endfunction

endpackage

/* rtl/ps2md_cfg.sv */
// Screen size registers for the PS/2 mouse decoder; keeps the highest legal coordinate.
// Depends on ps2md_pkg.
module ps2md_cfg #(
	parameter int COORD_BITS = ps2md_pkg::COORD_BITS_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic [ps2md_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ps2md_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output logic [COORD_BITS-1:0]                 top_x,
	output logic [COORD_BITS-1:0]                 top_y,
	output ps2md_pkg::recentre_t                  recentre
);

	localparam int EW = (COORD_BITS + 1 > ps2md_pkg::CFG_DATA_BITS) ?
		COORD_BITS + 1 : ps2md_pkg::CFG_DATA_BITS;
	localparam logic [COORD_BITS-1:0] TOP_X_RST = COORD_BITS'(
		ps2md_pkg::bound_top(ps2md_pkg::SCREEN_WIDTH_RESET, COORD_BITS));
	localparam logic [COORD_BITS-1:0] TOP_Y_RST = COORD_BITS'(
		ps2md_pkg::bound_top(ps2md_pkg::SCREEN_HEIGHT_RESET, COORD_BITS));
	localparam logic [EW-1:0] LIMIT = EW'(1) << COORD_BITS;

	logic [EW-1:0]         size_ext;
	logic [COORD_BITS-1:0] top_new;
	logic [COORD_BITS-1:0] top_x_q, top_y_q;
	ps2md_pkg::recentre_t  recentre_d;
	ps2md_pkg::recentre_t  recentre_q;

	// size 0 acts as 1, oversize saturates at the coordinate range
	always_comb begin
		size_ext = EW'(cfg_data);
		if (size_ext == '0)
			top_new = '0;
		else if (size_ext > LIMIT)
			top_new = '1;
		else
			top_new = COORD_BITS'(size_ext - EW'(1));
	end

	// one-cycle strobe for the coordinate whose size was written
	always_comb begin
		recentre_d = '0;
		if (cfg_valid) begin
			unique case (cfg_index)
				ps2md_pkg::REG_SCREEN_WIDTH:  recentre_d.x = 1'b1;
				ps2md_pkg::REG_SCREEN_HEIGHT: recentre_d.y = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_x_q    <= TOP_X_RST;
			top_y_q    <= TOP_Y_RST;
			recentre_q <= '0;
		end else begin
			recentre_q <= recentre_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					ps2md_pkg::REG_SCREEN_WIDTH: begin
						top_x_q <= top_new;
					end
					ps2md_pkg::REG_SCREEN_HEIGHT: begin
						top_y_q <= top_new;
					end
					default: ;
				endcase
			end
		end
	end

	assign top_x    = top_x_q;
	assign top_y    = top_y_q;
	assign recentre = recentre_q;

endmodule

/* rtl/ps2md_core.sv */
// Packet assembly, movement decode, clamped cursor and button edge logic.
// Depends on ps2md_pkg.
module ps2md_core #(
	parameter int COORD_BITS = ps2md_pkg::COORD_BITS_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   advance,
	input  logic [7:0]                             item_byte,
	input  logic [COORD_BITS-1:0]                  top_x,
	input  logic [COORD_BITS-1:0]                  top_y,
	input  ps2md_pkg::recentre_t                   recentre,
	output logic                                   produce,
	output logic [COORD_BITS-1:0]                  cursor_x,
	output logic [COORD_BITS-1:0]                  cursor_y,
	output logic [ps2md_pkg::MOVE_X_BITS-1:0]     move_x,
	output logic [ps2md_pkg::MOVE_Y_BITS-1:0]     move_y,
	output ps2md_pkg::btn_t                        buttons
);

	localparam int PW = COORD_BITS + 2;
	localparam int TOP_X_RST =
		ps2md_pkg::bound_top(ps2md_pkg::SCREEN_WIDTH_RESET, COORD_BITS);
	localparam int TOP_Y_RST =
		ps2md_pkg::bound_top(ps2md_pkg::SCREEN_HEIGHT_RESET, COORD_BITS);
	localparam logic [COORD_BITS-1:0] POS_X_RST = COORD_BITS'((TOP_X_RST + 1) / 2);
	localparam logic [COORD_BITS-1:0] POS_Y_RST = COORD_BITS'((TOP_Y_RST + 1) / 2);

	ps2md_pkg::phase_t     phase_q, phase_d;
	logic [7:0]            head_q, xbyte_q;
	logic [COORD_BITS-1:0] pos_x_q, pos_y_q;
	logic                  last_left_q, last_right_q;

	logic signed [8:0]     dx, dy;
	logic signed [9:0]     neg_dy;
	logic signed [PW-1:0]  sum_x, sum_y;
	logic [COORD_BITS-1:0] new_x, new_y;
	logic [COORD_BITS:0]   mid_x, mid_y;

	function automatic logic [COORD_BITS-1:0] clamp(
		input logic signed [PW-1:0] p,
		input logic [COORD_BITS-1:0] top
	);
		if (p[PW-1])
			return '0;
		if (p[PW-2:0] > (COORD_BITS+1)'(top))
			return top;
		return p[COORD_BITS-1:0];
	endfunction

	assign dx     = {head_q[ps2md_pkg::X_SIGN_BIT], xbyte_q};
	assign dy     = {head_q[ps2md_pkg::Y_SIGN_BIT], item_byte};
	assign neg_dy = -{dy[8], dy};
	assign sum_x  = $signed({2'b00, pos_x_q}) + PW'(dx);
	assign sum_y  = $signed({2'b00, pos_y_q}) + PW'(neg_dy);
	assign new_x  = clamp(sum_x, top_x);
	assign new_y  = clamp(sum_y, top_y);
	assign mid_x  = ({1'b0, top_x} + (COORD_BITS+1)'(1)) >> 1;
	assign mid_y  = ({1'b0, top_y} + (COORD_BITS+1)'(1)) >> 1;

	always_comb begin
		phase_d = ps2md_pkg::PH_HEAD;
		unique case (phase_q)
			ps2md_pkg::PH_X: phase_d = ps2md_pkg::PH_Y;
			ps2md_pkg::PH_Y: phase_d = ps2md_pkg::PH_HEAD;
			default: begin
				// unsynced head bytes are dropped
				if (item_byte[ps2md_pkg::SYNC_BIT])
					phase_d = ps2md_pkg::PH_X;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= ps2md_pkg::PH_HEAD;
			head_q       <= '0;
			xbyte_q      <= '0;
			pos_x_q      <= POS_X_RST;
			pos_y_q      <= POS_Y_RST;
			last_left_q  <= 1'b0;
			last_right_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q <= phase_d;
				if (phase_q == ps2md_pkg::PH_X)
					xbyte_q <= item_byte;
				else if (phase_q != ps2md_pkg::PH_Y && phase_d == ps2md_pkg::PH_X)
					head_q <= item_byte;
				if (produce) begin
					last_left_q  <= head_q[ps2md_pkg::LEFT_BIT];
					last_right_q <= head_q[ps2md_pkg::RIGHT_BIT];
				end
			end
			if (recentre.x)
				pos_x_q <= mid_x[COORD_BITS-1:0];
			else if (advance && produce)
				pos_x_q <= new_x;
			if (recentre.y)
				pos_y_q <= mid_y[COORD_BITS-1:0];
			else if (advance && produce)
				pos_y_q <= new_y;
		end
	end

	assign produce  = (phase_q == ps2md_pkg::PH_Y);
	assign cursor_x = new_x;
	assign cursor_y = new_y;
	assign move_x   = dx;
	assign move_y   = neg_dy;

	always_comb begin
		buttons.left_down     = head_q[ps2md_pkg::LEFT_BIT];
		buttons.right_down    = head_q[ps2md_pkg::RIGHT_BIT];
		buttons.middle_down   = head_q[ps2md_pkg::MIDDLE_BIT];
		buttons.left_pressed  = head_q[ps2md_pkg::LEFT_BIT] & ~last_left_q;
		buttons.left_let_go   = ~head_q[ps2md_pkg::LEFT_BIT] & last_left_q;
		buttons.right_pressed = head_q[ps2md_pkg::RIGHT_BIT] & ~last_right_q;
	end

endmodule

/* rtl/ps2_mouse_packet_decoder_unit.sv */
// Top level of the PS/2 mouse packet decoder: input register, decode core, result register.
// Depends on ps2md_pkg, ps2md_cfg and ps2md_core.
//
// Usage:
//  - s_axis: one mouse byte per request in tdata[7:0]. A head byte with bit 3
//    clear is dropped; head, X and Y bytes make one packet.
//  - m_axis: one result request per completed packet (cursor, movement, buttons
//    and button edges). Head and X bytes give no result.
//  - cfg: index 0 writes screen width, index 1 screen height; any other index
//    is ignored. A write recentres that coordinate. cfg_ready is always high;
//    write only while no byte is in flight.
//  - Path: an accepted Y byte is held in the input register, then its result is
//    loaded into the result register, which drives m_axis.
//  - Throughput: one byte per cycle unless a Y byte waits behind a full result
//    register; the decode is a single add and clamp per axis between the two.
//  - Stall: while m_axis_tready is low the result is held; bytes that give no
//    result keep flowing, and s_axis_tready drops only once a Y byte waits
//    behind a full result register.
//  - Reset: screen 1024 x 768 (clipped to the coordinate range), cursor at the
//    centre, no packet in progress, both channels empty.
module ps2_mouse_packet_decoder_unit #(
	parameter int COORD_BITS = ps2md_pkg::COORD_BITS_DEFAULT,
	localparam int OUT_BITS  = 2 * COORD_BITS + ps2md_pkg::MOVE_X_BITS +
		ps2md_pkg::MOVE_Y_BITS + $bits(ps2md_pkg::btn_t),
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// rx_byte [7:0]
	input  logic [7:0]                            s_axis_tdata,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// cursor_x, cursor_y, move_x, move_y, left_down, right_down, middle_down,
	// left_pressed, left_let_go, right_pressed; zero padded to bytes
	output logic [OUT_W-1:0]                      m_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ps2md_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ps2md_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  out_free, s1_fire, produce, s1_result;
	logic [COORD_BITS-1:0] top_x, top_y, cursor_x, cursor_y;
	logic [ps2md_pkg::MOVE_X_BITS-1:0] move_x;
	logic [ps2md_pkg::MOVE_Y_BITS-1:0] move_y;
	ps2md_pkg::btn_t       buttons;
	ps2md_pkg::recentre_t  recentre;
	logic                  m_valid_q;
	logic [OUT_W-1:0]      m_data_q;

	assign cfg_ready = 1'b1;

	ps2md_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.top_x    (top_x),
		.top_y    (top_y),
		.recentre (recentre)
	);

	// input stage moves on unless it holds a result and the output is blocked
	assign out_free      = ~m_valid_q | m_axis_tready;
	assign s1_result     = valid_s1 & produce;
	assign s1_fire       = valid_s1 & (~produce | out_free);
	assign s_axis_tready = ~valid_s1 | s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			byte_s1 <= s_axis_tdata;
	end

	ps2md_core #(.COORD_BITS(COORD_BITS)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (s1_fire),
		.item_byte(byte_s1),
		.top_x    (top_x),
		.top_y    (top_y),
		.recentre (recentre),
		.produce  (produce),
		.cursor_x (cursor_x),
		.cursor_y (cursor_y),
		.move_x   (move_x),
		.move_y   (move_y),
		.buttons  (buttons)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (out_free)
			m_valid_q <= s1_result;
	end

	always_ff @(posedge clk) begin
		if (s1_fire && produce)
			m_data_q <= OUT_W'({buttons, move_y, move_x, cursor_y, cursor_x});
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// a held input byte only waits on a blocked result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_fire |-> m_valid_q && !m_axis_tready)
		else $error("input stage stalled without output backpressure");

	// every completed packet lands in the result register
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && produce |=> m_valid_q)
		else $error("completed packet lost");

	// input is refused only while a byte is held
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1)
		else $error("input refused with empty input stage");

	// cursor never leaves the screen
	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && produce |-> cursor_x <= top_x && cursor_y <= top_y)
		else $error("cursor outside screen bounds");

endmodule
